/* hw/rtl/mfcb_pkg.sv */
// shared types, constants and helpers for the magnetometer frame check and baseline unit
`timescale 1ns / 1ps

package mfcb_pkg;

    localparam int NUM_AXES    = 9;
    localparam int AXIS_IDX_W  = 4;
    localparam int SAMPLE_W    = 16;
    localparam int TIME_W      = 32;
    localparam int CNT_W       = 11;
    localparam int SPACING_W   = 16;
    localparam int LIMIT_W     = 15;
    localparam int SUM_W       = 27;
    localparam int MAG_W       = SUM_W - 1;
    localparam int STEP_W      = $clog2(MAG_W);
    localparam int ZSUM_W      = SAMPLE_W + 2;
    localparam int MAX_SAMPLES = 1024;

    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int S_TDATA_W   = TIME_W + NUM_AXES * SAMPLE_W;
    localparam int M_TDATA_W   = 32;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;
    localparam logic [1:0] REG_MIN_SPACING  = 2'd1;
    localparam logic [1:0] REG_RANGE_LIMIT  = 2'd2;

    localparam logic [CNT_W-1:0]     RST_SAMPLE_COUNT = CNT_W'(100);
    localparam logic [SPACING_W-1:0] RST_MIN_SPACING  = SPACING_W'(10);
    localparam logic [LIMIT_W-1:0]   RST_RANGE_LIMIT  = LIMIT_W'(16000);

    // request kinds on s_tuser
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_FRAME = 1'b1;

    localparam logic [AXIS_IDX_W-1:0] LAST_AXIS = AXIS_IDX_W'(NUM_AXES - 1);

    typedef struct packed {
        logic [CNT_W-1:0]     sample_count;
        logic [SPACING_W-1:0] min_spacing;
        logic [LIMIT_W-1:0]   range_limit;
    } cfg_t;

    typedef struct packed {
        logic                       frame_valid;
        logic                       sample_taken;
        logic                       calib_active;
        logic                       calib_done;
        logic                       magnets_flipped;
        logic                       baseline_valid;
        logic [AXIS_IDX_W-1:0]      axis_index;
        logic signed [SAMPLE_W-1:0] baseline_value;
        logic                       last;
    } result_t;

    typedef struct packed {
        logic             start;
        logic             negative;
        logic [MAG_W-1:0] magnitude;
        logic [CNT_W-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DECIDE,
        ST_ACCUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } seq_state_t;

    // zero counts as one, anything above the cap as the cap
    function automatic logic [CNT_W-1:0] effective_count(input logic [CNT_W-1:0] sc);
        logic [CNT_W-1:0] n;
        n = sc;
        if (sc == '0) begin
            n = CNT_W'(1);
        end else if (sc > CNT_W'(MAX_SAMPLES)) begin
            n = CNT_W'(MAX_SAMPLES);
        end
        return n;
    endfunction

endpackage

/* hw/rtl/mfcb_apb_regs.sv */
// apb configuration registers of the magnetometer frame check and baseline unit
`timescale 1ns / 1ps

module mfcb_apb_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mfcb_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mfcb_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mfcb_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output mfcb_pkg::cfg_t                     cfg
);

    logic [mfcb_pkg::CNT_W-1:0]     sample_count_reg, sample_count_next;
    logic [mfcb_pkg::SPACING_W-1:0] min_spacing_reg, min_spacing_next;
    logic [mfcb_pkg::LIMIT_W-1:0]   range_limit_reg, range_limit_next;
    logic                           wr_en;
    logic [1:0]                     reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[3:2];

    always_comb begin
        sample_count_next = sample_count_reg;
        min_spacing_next  = min_spacing_reg;
        range_limit_next  = range_limit_reg;
        if (wr_en) begin
            unique case (reg_sel)
                mfcb_pkg::REG_SAMPLE_COUNT: sample_count_next = pwdata[mfcb_pkg::CNT_W-1:0];
                mfcb_pkg::REG_MIN_SPACING:  min_spacing_next  = pwdata[mfcb_pkg::SPACING_W-1:0];
                mfcb_pkg::REG_RANGE_LIMIT:  range_limit_next  = pwdata[mfcb_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= mfcb_pkg::RST_SAMPLE_COUNT;
            min_spacing_reg  <= mfcb_pkg::RST_MIN_SPACING;
            range_limit_reg  <= mfcb_pkg::RST_RANGE_LIMIT;
        end else begin
            sample_count_reg <= sample_count_next;
            min_spacing_reg  <= min_spacing_next;
            range_limit_reg  <= range_limit_next;
        end
    end

    always_comb begin
        unique case (reg_sel)
            mfcb_pkg::REG_SAMPLE_COUNT:
                prdata = mfcb_pkg::APB_DATA_W'(sample_count_reg);
            mfcb_pkg::REG_MIN_SPACING:
                prdata = mfcb_pkg::APB_DATA_W'(min_spacing_reg);
            mfcb_pkg::REG_RANGE_LIMIT:
                prdata = mfcb_pkg::APB_DATA_W'(range_limit_reg);
            default:
                prdata = '0;
        endcase
    end

    assign cfg.sample_count = sample_count_reg;
    assign cfg.min_spacing  = min_spacing_reg;
    assign cfg.range_limit  = range_limit_reg;

endmodule

/* hw/rtl/mfcb_divider.sv */
// shared restoring divider, one quotient bit a cycle, sign applied at the end
`timescale 1ns / 1ps

module mfcb_divider (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mfcb_pkg::div_cmd_t   cmd,
    output mfcb_pkg::div_rsp_t   rsp
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [mfcb_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [mfcb_pkg::MAG_W-1:0]       dvd_reg, dvd_next;
    logic [mfcb_pkg::CNT_W-1:0]       rem_reg, rem_next;
    logic [mfcb_pkg::CNT_W-1:0]       divisor_reg, divisor_next;
    logic                             neg_reg, neg_next;
    logic signed [mfcb_pkg::SAMPLE_W-1:0] quot_reg, quot_next;

    logic [mfcb_pkg::CNT_W:0]         trial;
    logic [mfcb_pkg::CNT_W:0]         diff;
    logic                             ge;
    logic [mfcb_pkg::MAG_W-1:0]       shifted;
    logic [mfcb_pkg::SAMPLE_W-1:0]    q_mag;

    // shift in the next dividend bit and try the subtract
    assign trial   = {rem_reg, dvd_reg[mfcb_pkg::MAG_W-1]};
    assign diff    = trial - {1'b0, divisor_reg};
    assign ge      = (trial >= {1'b0, divisor_reg});
    assign shifted = {dvd_reg[mfcb_pkg::MAG_W-2:0], ge};
    assign q_mag   = shifted[mfcb_pkg::SAMPLE_W-1:0];

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        neg_next     = neg_reg;
        quot_next    = quot_reg;
        if (cmd.start) begin
            busy_next    = 1'b1;
            step_next    = mfcb_pkg::STEP_W'(mfcb_pkg::MAG_W - 1);
            dvd_next     = cmd.magnitude;
            rem_next     = '0;
            divisor_next = cmd.divisor;
            neg_next     = cmd.negative;
        end else if (busy_reg) begin
            dvd_next = shifted;
            rem_next = ge ? diff[mfcb_pkg::CNT_W-1:0] : trial[mfcb_pkg::CNT_W-1:0];
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                // truncation toward zero: divide magnitudes, then restore the sign
                quot_next = neg_reg ? $signed(-q_mag) : $signed(q_mag);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
        quot_reg    <= quot_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

/* hw/rtl/mfcb_seq.sv */
// sequencer: frame check, sum update, baseline division and result emission
`timescale 1ns / 1ps

module mfcb_seq (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mfcb_pkg::cfg_t                      cfg,
    input  logic                                item_start,
    input  logic                                item_req,
    input  logic [mfcb_pkg::S_TDATA_W-1:0]      item_data,
    output logic                                item_ready,
    output logic                                res_valid,
    output mfcb_pkg::result_t                   res,
    input  logic                                res_load
);

    localparam int SW = mfcb_pkg::SAMPLE_W;

    mfcb_pkg::seq_state_t state_reg, state_next;

    logic [mfcb_pkg::AXIS_IDX_W-1:0]                idx_reg, idx_next;
    logic [mfcb_pkg::TIME_W-1:0]                    time_reg, time_next;
    logic [mfcb_pkg::NUM_AXES-1:0][SW-1:0]          samp_reg, samp_next;
    logic [mfcb_pkg::NUM_AXES-1:0][mfcb_pkg::SUM_W-1:0] sums_reg, sums_next;
    logic [mfcb_pkg::NUM_AXES-1:0][SW-1:0]          base_reg, base_next;
    logic [mfcb_pkg::CNT_W-1:0]                     cnt_reg, cnt_next;
    logic [mfcb_pkg::TIME_W-1:0]                    last_time_reg, last_time_next;
    logic                                           active_reg, active_next;
    logic                                           done_reg, done_next;
    logic                                           flipped_reg, flipped_next;
    logic                                           over_reg, over_next;
    logic [2:0]                                     live_reg, live_next;
    logic                                           valid_reg, valid_next;
    logic                                           taken_reg, taken_next;
    logic                                           finish_reg, finish_next;
    logic signed [mfcb_pkg::ZSUM_W-1:0]             zsum_reg, zsum_next;

    logic [SW-1:0]                                  cur;
    logic signed [SW:0]                             cur_ext;
    logic [SW:0]                                    cur_mag;
    logic [1:0]                                     sensor;
    logic                                           frame_ok;
    logic [mfcb_pkg::TIME_W-1:0]                    dt;
    logic                                           too_soon;
    logic [mfcb_pkg::CNT_W-1:0]                     cnt_inc;
    logic [mfcb_pkg::CNT_W-1:0]                     n_eff;
    logic [mfcb_pkg::SUM_W-1:0]                     cur_sum;
    logic [mfcb_pkg::SUM_W-1:0]                     sum_mag;
    logic                                           z_axis;
    logic signed [mfcb_pkg::ZSUM_W-1:0]             zsum_add;
    logic                                           out_last;
    mfcb_pkg::div_cmd_t                             div_cmd;
    mfcb_pkg::div_rsp_t                             div_rsp;

    mfcb_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .rsp     (div_rsp)
    );

    // per-axis views at the current index
    assign cur      = samp_reg[idx_reg];
    assign cur_ext  = {cur[SW-1], cur};
    assign cur_mag  = cur[SW-1] ? $unsigned(-cur_ext) : $unsigned(cur_ext);
    assign frame_ok = !over_reg && (&live_reg);
    assign dt       = time_reg - last_time_reg;
    assign too_soon = (last_time_reg != '0) &&
                      (dt < mfcb_pkg::TIME_W'(cfg.min_spacing));
    assign cnt_inc  = cnt_reg + 1'b1;
    assign n_eff    = mfcb_pkg::effective_count(cfg.sample_count);
    assign cur_sum  = sums_reg[idx_reg];
    assign sum_mag  = cur_sum[mfcb_pkg::SUM_W-1] ? -cur_sum : cur_sum;
    assign zsum_add = zsum_reg + {{2{div_rsp.quotient[SW-1]}}, div_rsp.quotient};
    assign out_last = !finish_reg || (idx_reg == mfcb_pkg::LAST_AXIS);

    always_comb begin
        case (idx_reg) inside
            [4'd0:4'd2]: sensor = 2'd0;
            [4'd3:4'd5]: sensor = 2'd1;
            default:     sensor = 2'd2;
        endcase
    end

    always_comb begin
        case (idx_reg) inside
            4'd2, 4'd5, 4'd8: z_axis = 1'b1;
            default:          z_axis = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mfcb_pkg::ST_IDLE: begin
                if (item_start) begin
                    state_next = (item_req == mfcb_pkg::REQ_START) ?
                                 mfcb_pkg::ST_EMIT : mfcb_pkg::ST_CHECK;
                end
            end
            mfcb_pkg::ST_CHECK: begin
                if (idx_reg == mfcb_pkg::LAST_AXIS) begin
                    state_next = mfcb_pkg::ST_DECIDE;
                end
            end
            mfcb_pkg::ST_DECIDE: begin
                state_next = (active_reg && !too_soon && frame_ok) ?
                             mfcb_pkg::ST_ACCUM : mfcb_pkg::ST_EMIT;
            end
            mfcb_pkg::ST_ACCUM: begin
                if (idx_reg == mfcb_pkg::LAST_AXIS) begin
                    state_next = finish_reg ? mfcb_pkg::ST_DIV_START : mfcb_pkg::ST_EMIT;
                end
            end
            mfcb_pkg::ST_DIV_START: begin
                state_next = mfcb_pkg::ST_DIV_WAIT;
            end
            mfcb_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    state_next = (idx_reg == mfcb_pkg::LAST_AXIS) ?
                                 mfcb_pkg::ST_EMIT : mfcb_pkg::ST_DIV_START;
                end
            end
            mfcb_pkg::ST_EMIT: begin
                if (res_load && out_last) begin
                    state_next = mfcb_pkg::ST_IDLE;
                end
            end
            default: state_next = mfcb_pkg::ST_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        idx_next       = idx_reg;
        time_next      = time_reg;
        samp_next      = samp_reg;
        sums_next      = sums_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        last_time_next = last_time_reg;
        active_next    = active_reg;
        done_next      = done_reg;
        flipped_next   = flipped_reg;
        over_next      = over_reg;
        live_next      = live_reg;
        valid_next     = valid_reg;
        taken_next     = taken_reg;
        finish_next    = finish_reg;
        zsum_next      = zsum_reg;
        unique case (state_reg)
            mfcb_pkg::ST_IDLE: begin
                if (item_start) begin
                    idx_next    = '0;
                    time_next   = item_data[mfcb_pkg::TIME_W-1:0];
                    samp_next   = item_data[mfcb_pkg::S_TDATA_W-1:mfcb_pkg::TIME_W];
                    over_next   = 1'b0;
                    live_next   = '0;
                    valid_next  = 1'b0;
                    taken_next  = 1'b0;
                    finish_next = 1'b0;
                    if (item_req == mfcb_pkg::REQ_START) begin
                        sums_next      = '0;
                        cnt_next       = '0;
                        last_time_next = '0;
                        active_next    = 1'b1;
                        done_next      = 1'b0;
                    end
                end
            end
            mfcb_pkg::ST_CHECK: begin
                // one axis a cycle through the shared magnitude compare
                if (cur_mag > (SW + 1)'(cfg.range_limit)) begin
                    over_next = 1'b1;
                end
                if (cur != '0) begin
                    live_next[sensor] = 1'b1;
                end
                idx_next = (idx_reg == mfcb_pkg::LAST_AXIS) ? '0 : idx_reg + 1'b1;
            end
            mfcb_pkg::ST_DECIDE: begin
                valid_next = frame_ok;
                idx_next   = '0;
                if (active_reg && !too_soon) begin
                    last_time_next = time_reg;
                    if (frame_ok) begin
                        taken_next = 1'b1;
                        cnt_next   = cnt_inc;
                        if (cnt_inc >= n_eff) begin
                            finish_next = 1'b1;
                            active_next = 1'b0;
                            done_next   = 1'b1;
                        end
                    end
                end
            end
            mfcb_pkg::ST_ACCUM: begin
                sums_next[idx_reg] = cur_sum +
                    {{(mfcb_pkg::SUM_W - SW){cur[SW-1]}}, cur};
                idx_next  = (idx_reg == mfcb_pkg::LAST_AXIS) ? '0 : idx_reg + 1'b1;
                zsum_next = '0;
            end
            mfcb_pkg::ST_DIV_START: ;
            mfcb_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    base_next[idx_reg] = div_rsp.quotient;
                    if (z_axis) begin
                        zsum_next = zsum_add;
                    end
                    if (idx_reg == mfcb_pkg::LAST_AXIS) begin
                        flipped_next = (zsum_add > 0);
                        idx_next     = '0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            mfcb_pkg::ST_EMIT: begin
                if (res_load && !out_last) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        item_ready       = 1'b0;
        res_valid        = 1'b0;
        div_cmd.start    = 1'b0;
        div_cmd.negative = cur_sum[mfcb_pkg::SUM_W-1];
        div_cmd.magnitude = sum_mag[mfcb_pkg::MAG_W-1:0];
        div_cmd.divisor  = n_eff;
        unique case (state_reg)
            mfcb_pkg::ST_IDLE:      item_ready    = 1'b1;
            mfcb_pkg::ST_DIV_START: div_cmd.start = 1'b1;
            mfcb_pkg::ST_EMIT:      res_valid     = 1'b1;
            default: ;
        endcase
    end

    assign res.frame_valid     = valid_reg;
    assign res.sample_taken    = taken_reg;
    assign res.calib_active    = active_reg;
    assign res.calib_done      = done_reg;
    assign res.magnets_flipped = flipped_reg;
    assign res.baseline_valid  = finish_reg;
    assign res.axis_index      = finish_reg ? idx_reg : '0;
    assign res.baseline_value  = finish_reg ? $signed(base_reg[idx_reg]) : '0;
    assign res.last            = out_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mfcb_pkg::ST_IDLE;
            idx_reg       <= '0;
            sums_reg      <= '0;
            base_reg      <= '0;
            cnt_reg       <= '0;
            last_time_reg <= '0;
            active_reg    <= 1'b0;
            done_reg      <= 1'b0;
            flipped_reg   <= 1'b0;
            finish_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            sums_reg      <= sums_next;
            base_reg      <= base_next;
            cnt_reg       <= cnt_next;
            last_time_reg <= last_time_next;
            active_reg    <= active_next;
            done_reg      <= done_next;
            flipped_reg   <= flipped_next;
            finish_reg    <= finish_next;
        end
    end

    always_ff @(posedge aclk) begin
        time_reg  <= time_next;
        samp_reg  <= samp_next;
        over_reg  <= over_next;
        live_reg  <= live_next;
        valid_reg <= valid_next;
        taken_reg <= taken_next;
        zsum_reg  <= zsum_next;
    end

endmodule

/* hw/rtl/magnetometer_frame_check_and_baseline_unit.sv */
// top level of the magnetometer frame check and baseline unit
`timescale 1ns / 1ps

// takes one item per transfer on the s_ side: a start-calibration request (s_tuser low)
// or a frame of nine signed axis samples with a millisecond timestamp (s_tuser high).
// a frame is checked one axis a cycle for range and dead sensors, then, if it passes,
// while calibrating and spaced far enough from the last recorded sample, added to the
// running sums one axis a cycle through a single adder. the frame that completes the
// count also runs nine divisions through one shared restoring divider that yields one
// quotient bit a cycle, and then gives nine result transfers, one per axis in input
// order, with m_tlast on the ninth. s_tready is high only while no item is in work; a
// finished result sits in the output register so the next item may be taken while it
// waits. configuration is written through the apb port; the user must do so only while
// idle, the block itself does not enforce this.
module magnetometer_frame_check_and_baseline_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // time_ms [31:0], bottom_x, bottom_y, bottom_z, left_x, left_y, left_z,
    // right_x, right_y, right_z, 16 bits each from bit 32 up
    input  logic [mfcb_pkg::S_TDATA_W-1:0]      s_tdata,
    // req_type [0]: 0 start calibration, 1 sensor frame
    input  logic [0:0]                          s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // frame_valid [0], sample_taken [1], calib_active [2], calib_done [3],
    // magnets_flipped [4], axis_index [8:5], baseline_value [24:9], zeros above
    output logic [mfcb_pkg::M_TDATA_W-1:0]      m_tdata,
    // baseline_valid [0]
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mfcb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mfcb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mfcb_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    mfcb_pkg::cfg_t     cfg;
    mfcb_pkg::result_t  res;
    logic               res_valid;
    logic               res_load;
    logic               item_ready;
    logic               item_start;

    // output register, parts the sequencer from the result side
    logic               out_valid_reg, out_valid_next;
    mfcb_pkg::result_t  out_reg, out_next;

    mfcb_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_tready   = item_ready;
    assign item_start = s_tvalid & item_ready;

    mfcb_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_start (item_start),
        .item_req   (s_tuser[0]),
        .item_data  (s_tdata),
        .item_ready (item_ready),
        .res_valid  (res_valid),
        .res        (res),
        .res_load   (res_load)
    );

    // load a new result when the register is empty or being emptied this cycle
    assign res_load = res_valid && (!out_valid_reg || m_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_load) begin
            out_valid_next = 1'b1;
            out_next       = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       out_reg.baseline_value,
                       out_reg.axis_index,
                       out_reg.magnets_flipped,
                       out_reg.calib_done,
                       out_reg.calib_active,
                       out_reg.sample_taken,
                       out_reg.frame_valid};
    assign m_tuser  = out_reg.baseline_valid;
    assign m_tlast  = out_reg.last;

endmodule

/* verif/testbench.sv */
// self-checking testbench for the magnetometer frame check and baseline unit
`timescale 1ns / 1ps

module testbench;
    import mfcb_pkg::*;

    // generous ceiling: a completing frame also runs its nine divisions before its nine transfers
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic                 kind;
        logic [S_TDATA_W-1:0] data;
    } stream_item_t;

    // ------------------------------------------------------------------ dut ports
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [0:0]            s_tuser  = REQ_START;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    magnetometer_frame_check_and_baseline_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------ bench state
    stream_item_t    frames_to_send[$];
    result_t         pending_results[$];
    int              mismatches = 0;
    int              cycles = 0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    logic            s_taken = 1'b0;

    // scratch for building a frame, and the time base of the generated sequence
    int              frame_axes [NUM_AXES];
    logic [TIME_W-1:0] gen_time;

    // configuration as the predictor sees it
    logic [CNT_W-1:0]     cfg_count   = RST_SAMPLE_COUNT;
    logic [SPACING_W-1:0] cfg_spacing = RST_MIN_SPACING;
    logic [LIMIT_W-1:0]   cfg_limit   = RST_RANGE_LIMIT;

    // calibration state as the predictor sees it
    logic signed [SUM_W-1:0]    acc_sum [NUM_AXES];
    logic signed [SAMPLE_W-1:0] baseline_q [NUM_AXES];
    logic [CNT_W-1:0]           taken_count = '0;
    logic [TIME_W-1:0]          last_time   = '0;
    logic                       active_q    = 1'b0;
    logic                       done_q      = 1'b0;
    logic                       flipped_q   = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------ predictor
    // applies one accepted item to the calibration state and queues the results it causes
    function automatic void advance_baseline_state(input logic kind,
                                                   input logic [S_TDATA_W-1:0] d);
        logic signed [SAMPLE_W-1:0] smp [NUM_AXES];
        logic [TIME_W-1:0]          now;
        logic [CNT_W-1:0]           n;
        logic                       ok;
        logic                       took;
        logic                       finished;
        int                         mag;
        int                         zsum;
        result_t                    r;
        ok       = 1'b0;
        took     = 1'b0;
        finished = 1'b0;
        if (kind == REQ_START) begin
            // restart: sums, count and last time cleared, baselines and flip kept
            for (int i = 0; i < NUM_AXES; i++) begin
                acc_sum[i] = '0;
            end
            taken_count = '0;
            last_time   = '0;
            active_q    = 1'b1;
            done_q      = 1'b0;
        end else begin
            now = d[TIME_W-1:0];
            ok  = 1'b1;
            for (int i = 0; i < NUM_AXES; i++) begin
                smp[i] = d[TIME_W + SAMPLE_W * i +: SAMPLE_W];
                mag    = (smp[i] < 0) ? -int'(smp[i]) : int'(smp[i]);
                if (mag > int'(cfg_limit)) begin
                    ok = 1'b0;
                end
            end
            // a sensor reading zero on all three axes is taken as dead
            for (int s = 0; s < 3; s++) begin
                if (smp[3 * s] == 0 && smp[3 * s + 1] == 0 && smp[3 * s + 2] == 0) begin
                    ok = 1'b0;
                end
            end
            // recorded time of zero disables the spacing check; difference wraps
            if (active_q && !(last_time != '0 &&
                              (now - last_time) < TIME_W'(cfg_spacing))) begin
                last_time = now;
                if (ok) begin
                    n = cfg_count;
                    if (n == '0) begin
                        n = CNT_W'(1);
                    end else if (n > CNT_W'(MAX_SAMPLES)) begin
                        n = CNT_W'(MAX_SAMPLES);
                    end
                    took = 1'b1;
                    for (int i = 0; i < NUM_AXES; i++) begin
                        acc_sum[i] = acc_sum[i] + smp[i];
                    end
                    taken_count = taken_count + 1'b1;
                    if (taken_count >= n) begin
                        // signed integer division truncates toward zero
                        for (int i = 0; i < NUM_AXES; i++) begin
                            baseline_q[i] = SAMPLE_W'(int'(acc_sum[i]) / int'(n));
                        end
                        zsum = int'(baseline_q[2]) + int'(baseline_q[5]) + int'(baseline_q[8]);
                        flipped_q = (zsum > 0);
                        active_q  = 1'b0;
                        done_q    = 1'b1;
                        finished  = 1'b1;
                    end
                end
            end
        end
        r.frame_valid     = ok;
        r.sample_taken    = took;
        r.calib_active    = active_q;
        r.calib_done      = done_q;
        r.magnets_flipped = flipped_q;
        if (finished) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r.baseline_valid = 1'b1;
                r.axis_index     = AXIS_IDX_W'(i);
                r.baseline_value = baseline_q[i];
                r.last           = (i == NUM_AXES - 1);
                pending_results.push_back(r);
            end
        end else begin
            r.baseline_valid = 1'b0;
            r.axis_index     = '0;
            r.baseline_value = '0;
            r.last           = 1'b1;
            pending_results.push_back(r);
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t mismatch in %s: expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------ monitor
    // samples both channels at the rising edge, before the dut's registers move
    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        s_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            got.frame_valid     = m_tdata[0];
            got.sample_taken    = m_tdata[1];
            got.calib_active    = m_tdata[2];
            got.calib_done      = m_tdata[3];
            got.magnets_flipped = m_tdata[4];
            got.axis_index      = m_tdata[8:5];
            got.baseline_value  = m_tdata[24:9];
            got.baseline_valid  = m_tuser[0];
            got.last            = m_tlast;
            if (pending_results.size() == 0) begin
                $display("%0t mismatch: expected no transfer, got tdata %h tuser %b tlast %b",
                         $time, m_tdata, m_tuser, m_tlast);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("frame_valid", want.frame_valid, got.frame_valid);
                check_field("sample_taken", want.sample_taken, got.sample_taken);
                check_field("calib_active", want.calib_active, got.calib_active);
                check_field("calib_done", want.calib_done, got.calib_done);
                check_field("magnets_flipped", want.magnets_flipped, got.magnets_flipped);
                check_field("baseline_valid", want.baseline_valid, got.baseline_valid);
                check_field("axis_index", want.axis_index, got.axis_index);
                check_field("baseline_value", int'(want.baseline_value),
                            int'(got.baseline_value));
                check_field("last", want.last, got.last);
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            advance_baseline_state(s_tuser[0], s_tdata);
        end
    end

    // ------------------------------------------------------------------ driver
    // falling edge: offer the next item once the previous transfer has happened,
    // with random gaps on the input side and random stalls on the result side
    always @(negedge aclk) begin : driver
        stream_item_t nxt;
        if (aresetn && (!s_tvalid || s_taken)) begin
            if (frames_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = frames_to_send.pop_front();
                s_tdata  <= nxt.data;
                s_tuser  <= nxt.kind;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // timeout guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------ item building
    function automatic void queue_start();
        stream_item_t it;
        it.kind = REQ_START;
        // the payload of a start request is meaningless, so fill it with noise
        for (int j = 0; j < S_TDATA_W; j += 16) begin
            it.data[j +: 16] = 16'($urandom);
        end
        frames_to_send.push_back(it);
    endfunction

    function automatic void queue_frame(input logic [TIME_W-1:0] t);
        stream_item_t it;
        it.kind = REQ_FRAME;
        it.data = '0;
        it.data[TIME_W-1:0] = t;
        for (int i = 0; i < NUM_AXES; i++) begin
            it.data[TIME_W + SAMPLE_W * i +: SAMPLE_W] = SAMPLE_W'(frame_axes[i]);
        end
        frames_to_send.push_back(it);
    endfunction

    // a sample within +-lim, now and then right on the edge
    function automatic int sane_axis(input int lim);
        if ($urandom_range(0, 15) == 0) begin
            return ($urandom_range(0, 1) != 0) ? lim : -lim;
        end
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // a sample whose magnitude is strictly above lim; 32768 folds onto the most negative
    function automatic int wild_axis(input int lim);
        int mag;
        int v;
        mag = int'($urandom_range(lim + 1, 32768));
        v   = ($urandom_range(0, 1) != 0) ? -mag : mag;
        if (v == 32768) begin
            v = -32768;
        end
        return v;
    endfunction

    // calibration runs with random content: mostly well-formed and spaced frames,
    // the rest spaced-out, out-of-range, dead-sensor and fully random frames
    function automatic void queue_random_items(input int count);
        int   lim;
        int   gap;
        int   eff;
        int   r;
        int   wellformed;
        int   s;
        logic spaced_out;
        logic signed [SAMPLE_W-1:0] raw;
        logic [TIME_W-1:0] t;
        lim = int'(cfg_limit);
        gap = int'(cfg_spacing);
        eff = int'(cfg_count);
        if (eff == 0) begin
            eff = 1;
        end else if (eff > MAX_SAMPLES) begin
            eff = MAX_SAMPLES;
        end
        queue_start();
        wellformed = 0;
        for (int k = 1; k < count; k++) begin
            r = int'($urandom_range(0, 99));
            // restart soon after the run should have completed, seldom at random
            if ((wellformed >= eff && r < 90) || r < 4) begin
                queue_start();
                wellformed = 0;
            end else begin
                spaced_out = 1'b0;
                for (int i = 0; i < NUM_AXES; i++) begin
                    frame_axes[i] = sane_axis(lim);
                end
                t = gen_time + TIME_W'(gap) + TIME_W'($urandom_range(0, 20));
                if (r < 74) begin
                    for (int q = 0; q < 3; q++) begin
                        if (lim > 0 && frame_axes[3 * q] == 0 && frame_axes[3 * q + 1] == 0
                            && frame_axes[3 * q + 2] == 0) begin
                            frame_axes[3 * q + int'($urandom_range(0, 2))] =
                                ($urandom_range(0, 1) != 0) ? 1 : -1;
                        end
                    end
                    wellformed++;
                end else if (r < 81 && gap > 0) begin
                    t = gen_time + TIME_W'($urandom_range(0, gap - 1));
                    spaced_out = 1'b1;
                end else if (r < 87) begin
                    frame_axes[$urandom_range(0, NUM_AXES - 1)] = wild_axis(lim);
                end else if (r < 92) begin
                    s = int'($urandom_range(0, 2));
                    frame_axes[3 * s]     = 0;
                    frame_axes[3 * s + 1] = 0;
                    frame_axes[3 * s + 2] = 0;
                end else begin
                    t = (r == 99) ? '0 : TIME_W'($urandom);
                    for (int i = 0; i < NUM_AXES; i++) begin
                        raw = SAMPLE_W'($urandom);
                        frame_axes[i] = raw;
                    end
                end
                if (!spaced_out) begin
                    gen_time = t;
                end
                queue_frame(t);
            end
        end
    endfunction

    // ------------------------------------------------------------------ apb access
    task automatic reg_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
        logic [APB_DATA_W-1:0] got;
        logic [APB_DATA_W-1:0] want;
        // setup then access phase of the write
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SAMPLE_COUNT: cfg_count   = val[CNT_W-1:0];
            REG_MIN_SPACING:  cfg_spacing = val[SPACING_W-1:0];
            REG_RANGE_LIMIT:  cfg_limit   = val[LIMIT_W-1:0];
            default: ;
        endcase
        // read it back
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SAMPLE_COUNT: want = APB_DATA_W'(cfg_count);
            REG_MIN_SPACING:  want = APB_DATA_W'(cfg_spacing);
            default:          want = APB_DATA_W'(cfg_limit);
        endcase
        if (got !== want) begin
            $display("%0t mismatch in register %0d readback: expected %h, got %h",
                     $time, idx, want, got);
            mismatches++;
        end
    endtask

    task automatic write_config(input int count, input int spacing, input int limit);
        reg_write(REG_SAMPLE_COUNT, APB_DATA_W'(count));
        reg_write(REG_MIN_SPACING, APB_DATA_W'(spacing));
        reg_write(REG_RANGE_LIMIT, APB_DATA_W'(limit));
    endtask

    // every item gives a result, so once the last one is out the unit is idle
    task automatic wait_idle();
        do @(posedge aclk);
        while (frames_to_send.size() != 0 || s_tvalid || pending_results.size() != 0);
        repeat (10) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------ stimulus
    initial begin : stimulus
        for (int i = 0; i < NUM_AXES; i++) begin
            acc_sum[i]    = '0;
            baseline_q[i] = '0;
        end
        gen_time = $urandom;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // phase one: slow receiver
        send_idle_pct = 14;
        recv_idle_pct = 81;
        write_config(3, 10, 16000);

        // frames while idle: sane, most negative sample, dead left sensor
        frame_axes = '{100, -200, 300, -400, 500, -600, 700, -800, 900};
        queue_frame(32'd100);
        frame_axes = '{-32768, 1, 1, 1, 1, 1, 1, 1, 1};
        queue_frame(32'd200);
        frame_axes = '{5, 5, 5, 0, 0, 0, 5, 5, 5};
        queue_frame(32'd300);
        queue_start();
        // time zero is recorded but leaves the next frame unchecked for spacing
        frame_axes = '{16000, -16000, 7, 1, 2, 3, -4, -5, -6};
        queue_frame(32'd0);
        frame_axes = '{1, 1, 1, 0, 0, -1, 2, 2, 2};
        queue_frame(32'd4);
        queue_frame(32'd9);                 // too soon after 4
        frame_axes = '{1, 1, 1, 1, 1, 16001, 1, 1, 1};
        queue_frame(32'd14);                // out of range, time still recorded
        frame_axes = '{1, 1, 1, 0, 0, -1, 2, 2, 2};
        queue_frame(32'd23);                // too soon after 14
        // completes the run: negative sums truncate toward zero, z sum positive
        frame_axes = '{-16000, 16000, 0, 0, 5, 0, 0, 0, 9};
        queue_frame(32'd24);
        queue_frame(32'd100);               // done, so ignored apart from the check
        queue_start();
        queue_start();                      // restart while already active
        frame_axes = '{-7, -7, -7, -7, -7, -7, -7, -7, -7};
        queue_frame(32'hFFFF_FFFF);
        queue_frame(32'd8);                 // wrapped difference of nine
        frame_axes = '{-8, -8, -8, -8, -8, -8, -8, -8, -8};
        queue_frame(32'd9);                 // wrapped difference of exactly the spacing
        frame_axes = '{32767, 1, 1, 1, 1, 1, 1, 1, 1};
        queue_frame(32'd20);
        frame_axes = '{-9, -9, -9, -9, -9, -9, -9, -9, -9};
        queue_frame(32'd40);                // completes with negative z sum
        wait_idle();

        // zero count acts as one, no spacing, widest range
        write_config(0, 0, 32767);
        queue_random_items(60);
        wait_idle();

        // phase two: slow sender
        send_idle_pct = 81;
        recv_idle_pct = 14;
        // count above the cap, widest spacing, zero range: nothing can be valid
        write_config(2047, 65535, 0);
        queue_random_items(15);
        wait_idle();

        write_config(5, 65535, 12000);
        queue_random_items(80);
        wait_idle();

        // phase three: no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_config(1, 1, 1);
        queue_random_items(20);
        wait_idle();

        write_config(7, 300, 20000);
        queue_random_items(90);
        wait_idle();
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* magnetometer_frame_check_and_baseline_unit.f */
hw/rtl/mfcb_pkg.sv
hw/rtl/mfcb_apb_regs.sv
hw/rtl/mfcb_divider.sv
hw/rtl/mfcb_seq.sv
hw/rtl/magnetometer_frame_check_and_baseline_unit.sv
verif/testbench.sv
